### rtl/lsem_pkg.sv
// ----------------------------------------------------------------------------
// lsem_pkg
// Shared types and constants for the level set edge map block.
// ----------------------------------------------------------------------------
package lsem_pkg;

    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_HEIGHT_DEF     = 1024;
    localparam int COMPONENT_BITS_DEF = 16;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_W     = 11;
    localparam int COUNT_W    = 22;

    localparam logic [SIZE_W-1:0]     SIZE_RESET = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] BOUND_MAX  = 16'hFFFF;
    localparam logic [COUNT_W-1:0]    COUNT_MAX  = 22'h3FFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_INTENSITY   = 3'd0,
        REG_LOW_HUE         = 3'd1,
        REG_LOW_SATURATION  = 3'd2,
        REG_HIGH_INTENSITY  = 3'd3,
        REG_HIGH_HUE        = 3'd4,
        REG_HIGH_SATURATION = 3'd5,
        REG_IMAGE_WIDTH     = 3'd6,
        REG_IMAGE_HEIGHT    = 3'd7
    } cfg_index_t;

    // One bound of the lexicographic range
    typedef struct packed {
        logic [CFG_DATA_W-1:0] intensity;
        logic [CFG_DATA_W-1:0] hue;
        logic [CFG_DATA_W-1:0] saturation;
    } bound_t;

    // Where the pixel sits in the frame
    typedef struct packed {
        logic col_first;
        logic row_first;
        logic last_col;
        logic last_row;
    } pos_t;

endpackage

### rtl/lsem_ram.sv
// ----------------------------------------------------------------------------
// lsem_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lsem_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lsem_member.sv
// ----------------------------------------------------------------------------
// lsem_member
// Range test of one pixel against the low and high bounds, ordered by
// intensity, then hue, then saturation. Both bounds inclusive.
// ----------------------------------------------------------------------------
module lsem_member import lsem_pkg::*; #(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic [COMPONENT_BITS-1:0] hue,
    input  logic [COMPONENT_BITS-1:0] saturation,
    input  logic [COMPONENT_BITS-1:0] intensity,
    input  bound_t                    low_bound,
    input  bound_t                    high_bound,
    output logic                      in_range
);

    logic [3*COMPONENT_BITS-1:0] pixel_key;
    logic [3*COMPONENT_BITS-1:0] low_key;
    logic [3*COMPONENT_BITS-1:0] high_key;

    // Concatenated keys compare lexicographically as one unsigned word
    assign pixel_key = {intensity, hue, saturation};
    assign low_key   = {COMPONENT_BITS'(low_bound.intensity),
                        COMPONENT_BITS'(low_bound.hue),
                        COMPONENT_BITS'(low_bound.saturation)};
    assign high_key  = {COMPONENT_BITS'(high_bound.intensity),
                        COMPONENT_BITS'(high_bound.hue),
                        COMPONENT_BITS'(high_bound.saturation)};

    assign in_range = (pixel_key >= low_key) && (pixel_key <= high_key);

endmodule

### rtl/lsem_position.sv
// ----------------------------------------------------------------------------
// lsem_position
// Column and row counters of the raster scan, with the frame size clamped
// to the supported range.
// ----------------------------------------------------------------------------
module lsem_position import lsem_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [SIZE_W-1:0]             image_width,
    input  logic [SIZE_W-1:0]             image_height,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output pos_t                          pos
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [XW-1:0] width_eff;
    logic [YW-1:0] height_eff;

    always_comb
    begin
        priority if (image_width < SIZE_W'(2))
            width_eff = XW'(2);
        else if (32'(image_width) > 32'(MAX_WIDTH))
            width_eff = XW'(MAX_WIDTH);
        else
            width_eff = XW'(image_width);

        priority if (image_height < SIZE_W'(2))
            height_eff = YW'(2);
        else if (32'(image_height) > 32'(MAX_HEIGHT))
            height_eff = YW'(MAX_HEIGHT);
        else
            height_eff = YW'(image_height);
    end

    assign col           = col_reg;
    assign pos.col_first = (col_reg == '0);
    assign pos.row_first = (row_reg == '0);
    assign pos.last_col  = (XW'(col_reg) + XW'(1)) >= width_eff;
    assign pos.last_row  = (YW'(row_reg) + YW'(1)) >= height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            if (pos.last_col)
            begin
                col_reg <= '0;
                if (pos.last_row)
                    row_reg <= '0;
                else
                    row_reg <= row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

endmodule

### rtl/level_set_edge_map.sv
// ----------------------------------------------------------------------------
// level_set_edge_map
// Streaming boundary edge map and crossing point counter for one level set.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (hue, saturation, intensity) in raster
// order; each request yields one result request with the inside flag, the
// left and up edge flags, the running crossing point count and count_done,
// which marks the last pixel of the frame and the final count.
// Bounds and frame size are written on the cfg channel (cfg_ready is always
// high); the user must write them only while no pixel is in flight, which the
// block does not enforce. Writes do not restart the frame. A pixel passes
// the compute register, then the result register. Throughput: one pixel per
// cycle while result_ready stays high.
// After reset the previous-row memory is cleared, one entry per cycle, over
// all MAX_WIDTH entries (1024 by default); pixel_ready stays low meanwhile.
// When result_ready is low the result register holds; one more pixel may
// enter the compute register, then pixel_ready drops until the result drains.
// ----------------------------------------------------------------------------
module level_set_edge_map import lsem_pkg::*; #(
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      pixel_valid,
    output logic                      pixel_ready,
    input  logic [COMPONENT_BITS-1:0] hue,
    input  logic [COMPONENT_BITS-1:0] saturation,
    input  logic [COMPONENT_BITS-1:0] intensity,

    output logic                      result_valid,
    input  logic                      result_ready,
    output logic                      pixel_inside,
    output logic                      left_edge,
    output logic                      up_edge,
    output logic [COUNT_W-1:0]        point_count,
    output logic                      count_done,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Configuration
    bound_t            low_reg;
    bound_t            high_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    // Clearing pass
    logic          clr_active_reg;
    logic [CW-1:0] clr_addr_reg;

    // Position of the next pixel
    logic [CW-1:0] pos_col;
    pos_t          pos_now;

    // Compute stage
    logic                      s1_valid_reg;
    logic [COMPONENT_BITS-1:0] s1_hue_reg;
    logic [COMPONENT_BITS-1:0] s1_sat_reg;
    logic [COMPONENT_BITS-1:0] s1_int_reg;
    logic [CW-1:0]             s1_col_reg;
    pos_t                      s1_pos_reg;

    // Neighborhood state
    logic               left_inside_reg;
    logic               upper_left_reg;
    logic [COUNT_W-1:0] total_reg;

    // Result register
    logic               result_valid_reg;
    logic               inside_out_reg;
    logic               left_out_reg;
    logic               up_out_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic               done_out_reg;

    logic               accept;
    logic               out_advance;
    logic               cur;
    logic               above;
    logic               left_e;
    logic               up_e;
    logic               frame_end;
    logic [2:0]         cell_sum;
    logic [1:0]         cell_add;
    logic [2:0]         inc;
    logic [COUNT_W:0]   sum_wide;
    logic [COUNT_W-1:0] total_next;
    logic               ram_wr_en;
    logic [CW-1:0]      ram_wr_addr;
    logic               ram_wr_data;

    // ---------------------------------------------------------------- handshake
    assign out_advance  = s1_valid_reg && (!result_valid_reg || result_ready);
    assign pixel_ready  = !clr_active_reg && (!s1_valid_reg || out_advance);
    assign accept       = pixel_valid && pixel_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= '0;
            high_reg   <= {BOUND_MAX, BOUND_MAX, BOUND_MAX};
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOW_INTENSITY:   low_reg.intensity   <= cfg_data;
                REG_LOW_HUE:         low_reg.hue         <= cfg_data;
                REG_LOW_SATURATION:  low_reg.saturation  <= cfg_data;
                REG_HIGH_INTENSITY:  high_reg.intensity  <= cfg_data;
                REG_HIGH_HUE:        high_reg.hue        <= cfg_data;
                REG_HIGH_SATURATION: high_reg.saturation <= cfg_data;
                REG_IMAGE_WIDTH:     width_reg  <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:    height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- clear pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + CW'(1);
            if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- position
    lsem_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col          (pos_col),
        .pos          (pos_now)
    );

    // ---------------------------------------------------------------- row store
    // Read ahead at accept so the pixel above arrives with the compute stage
    assign ram_wr_en   = clr_active_reg || out_advance;
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : s1_col_reg;
    assign ram_wr_data = clr_active_reg ? 1'b0 : cur;

    lsem_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (pos_col),
        .rd_data (above)
    );

    // ---------------------------------------------------------------- compute stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (out_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hue_reg <= hue;
            s1_sat_reg <= saturation;
            s1_int_reg <= intensity;
            s1_col_reg <= pos_col;
            s1_pos_reg <= pos_now;
        end
    end

    lsem_member #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_member (
        .hue        (s1_hue_reg),
        .saturation (s1_sat_reg),
        .intensity  (s1_int_reg),
        .low_bound  (low_reg),
        .high_bound (high_reg),
        .in_range   (cur)
    );

    assign left_e    = !s1_pos_reg.col_first && (cur != left_inside_reg);
    assign up_e      = !s1_pos_reg.row_first && (cur != above);
    assign frame_end = s1_pos_reg.last_row && s1_pos_reg.last_col;

    always_comb
    begin
        cell_sum = 3'(upper_left_reg != above) + 3'(upper_left_reg != left_inside_reg)
                 + 3'(left_e) + 3'(up_e);
        if (s1_pos_reg.row_first || s1_pos_reg.col_first || cell_sum == 3'd0)
            cell_add = 2'd0;
        else if (cell_sum == 3'd4)
            cell_add = 2'd2;
        else
            cell_add = 2'd1;
        // Border crossings on the outer rows and columns
        inc = 3'(cell_add)
            + 3'((s1_pos_reg.row_first || s1_pos_reg.last_row) && left_e)
            + 3'((s1_pos_reg.col_first || s1_pos_reg.last_col) && up_e);
        sum_wide   = {1'b0, total_reg} + (COUNT_W + 1)'(inc);
        total_next = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_inside_reg <= 1'b0;
            upper_left_reg  <= 1'b0;
            total_reg       <= '0;
        end
        else if (out_advance)
        begin
            left_inside_reg <= cur;
            upper_left_reg  <= above;
            total_reg       <= frame_end ? '0 : total_next;
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_advance)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_advance)
        begin
            inside_out_reg <= cur;
            left_out_reg   <= left_e;
            up_out_reg     <= up_e;
            count_out_reg  <= total_next;
            done_out_reg   <= frame_end;
        end
    end

    assign pixel_inside = inside_out_reg;
    assign left_edge    = left_out_reg;
    assign up_edge      = up_out_reg;
    assign point_count  = count_out_reg;
    assign count_done   = done_out_reg;

    // ---------------------------------------------------------------- assertions
    a_no_pixel_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!pixel_ready && !s1_valid_reg))
        else $error("pixel taken during row store clear");

    a_total_cleared_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_advance && frame_end) |=> (total_reg == '0))
        else $error("crossing total not cleared after last pixel");

    a_total_grows_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_advance && !frame_end) |=> (total_reg >= $past(total_reg)))
        else $error("crossing total decreased within a frame");

    a_result_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> $stable(count_out_reg))
        else $error("result count changed while stalled");

endmodule

### tb/level_set_edge_map_tb.sv
// ----------------------------------------------------------------------------
// level_set_edge_map_tb
// Self-checking bench for the level set edge map. HSI pixels and register
// writes are driven over their valid/ready channels, pixels with random gaps
// and results with random stalls. A scoreboard predicts the inside flag, both
// edge flags, the running crossing count and the frame end for every pixel,
// and checks the results in order. It covers size clamping, size changes in a
// frame, empty ranges and ranges with equal bounds, and cells with all edges set.
// ----------------------------------------------------------------------------
module level_set_edge_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsem_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 520;
    localparam int MAX_REPORTS  = 20;

    typedef struct packed {
        logic               in_flag;
        logic               left_flag;
        logic               up_flag;
        logic [COUNT_W-1:0] count;
        logic               done;
    } edge_result_t;

    // Holds its own copy of the bounds, the frame position and the previous
    // row, and queues one expected result per accepted pixel request.
    class edge_map_checker;
        bound_t                   low_bound  = '0;
        bound_t                   high_bound = '1;
        logic [SIZE_W-1:0]        width_reg  = SIZE_RESET;
        logic [SIZE_W-1:0]        height_reg = SIZE_RESET;
        logic [MAX_WIDTH_DEF-1:0] prev_row   = '0;
        logic                     left_in    = 1'b0;
        logic                     corner_in  = 1'b0;
        int unsigned              col        = 0;
        int unsigned              row        = 0;
        int unsigned              total      = 0;
        edge_result_t             awaited[$];
        int                       mismatches = 0;

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LOW_INTENSITY:   low_bound.intensity   = data;
                REG_LOW_HUE:         low_bound.hue         = data;
                REG_LOW_SATURATION:  low_bound.saturation  = data;
                REG_HIGH_INTENSITY:  high_bound.intensity  = data;
                REG_HIGH_HUE:        high_bound.hue        = data;
                REG_HIGH_SATURATION: high_bound.saturation = data;
                REG_IMAGE_WIDTH:     width_reg             = data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:    height_reg            = data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned limit);
            if (v < 2)
                return 2;
            if (v > limit)
                return limit;
            return v;
        endfunction

        function void add_points(int unsigned n);
            total = (total + n > COUNT_MAX) ? COUNT_MAX : total + n;
        endfunction

        function void take_pixel(bound_t pix);
            int unsigned  w;
            int unsigned  h;
            int unsigned  slot;
            int unsigned  crossings;
            logic         last_col;
            logic         last_row;
            logic         above;
            edge_result_t r;

            w        = clamp_size(width_reg, MAX_WIDTH_DEF);
            h        = clamp_size(height_reg, MAX_HEIGHT_DEF);
            last_col = (col + 1 >= w);
            last_row = (row + 1 >= h);
            slot     = (col < MAX_WIDTH_DEF) ? col : MAX_WIDTH_DEF - 1;
            above    = prev_row[slot];

            // packed compare of {intensity, hue, saturation} is the lexicographic order
            r.in_flag   = (pix >= low_bound) && (pix <= high_bound);
            r.left_flag = (col > 0) && (r.in_flag != left_in);
            r.up_flag   = (row > 0) && (r.in_flag != above);

            // a cell closes at its lower-right pixel
            if (row > 0 && col > 0)
            begin
                crossings = int'(corner_in != above) + int'(corner_in != left_in)
                          + int'(r.left_flag) + int'(r.up_flag);
                if (crossings != 0)
                    add_points(crossings == 4 ? 2 : 1);
            end
            if ((row == 0 || last_row) && r.left_flag)
                add_points(1);
            if ((col == 0 || last_col) && r.up_flag)
                add_points(1);

            r.done  = last_row && last_col;
            r.count = total[COUNT_W-1:0];
            awaited.push_back(r);

            corner_in      = above;
            prev_row[slot] = r.in_flag;
            left_in        = r.in_flag;

            // wrap at the last column; a frame end clears the count
            if (last_col)
            begin
                col = 0;
                if (last_row)
                begin
                    row   = 0;
                    total = 0;
                end
                else
                begin
                    row++;
                end
            end
            else
            begin
                col++;
            end
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("t=%0t %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
        endfunction

        function void match_result(edge_result_t got);
            edge_result_t want;

            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("t=%0t result with no pixel request pending: expected none, actual %h",
                             $time, got);
                return;
            end
            want = awaited.pop_front();
            if (got.in_flag !== want.in_flag)
                report("pixel_inside", want.in_flag, got.in_flag);
            if (got.left_flag !== want.left_flag)
                report("left_edge", want.left_flag, got.left_flag);
            if (got.up_flag !== want.up_flag)
                report("up_edge", want.up_flag, got.up_flag);
            if (got.count !== want.count)
                report("point_count", want.count, got.count);
            if (got.done !== want.done)
                report("count_done", want.done, got.done);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_ready;
    logic [CFG_DATA_W-1:0] hue;
    logic [CFG_DATA_W-1:0] saturation;
    logic [CFG_DATA_W-1:0] intensity;
    logic                  result_valid;
    logic                  result_ready;
    logic                  pixel_inside;
    logic                  left_edge;
    logic                  up_edge;
    logic [COUNT_W-1:0]    point_count;
    logic                  count_done;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    edge_map_checker       sb;
    logic [1:0]            idle_mode;   // bit 0: pixel side gaps, bit 1: result side stalls
    bound_t                lo_now;
    bound_t                hi_now;
    int                    random_sent;

    level_set_edge_map u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .hue          (hue),
        .saturation   (saturation),
        .intensity    (intensity),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel_inside (pixel_inside),
        .left_edge    (left_edge),
        .up_edge      (up_edge),
        .point_count  (point_count),
        .count_done   (count_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Pick a component at or next to a bound most of the time
    function automatic logic [CFG_DATA_W-1:0] near(logic [CFG_DATA_W-1:0] lo,
                                                   logic [CFG_DATA_W-1:0] hi);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            2:       return lo - 16'd1;
            3:       return hi + 16'd1;
            4:       return lo + 16'd1;
            5:       return hi - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bound_t pick_pixel();
        bound_t p;

        if ($urandom_range(0, 7) == 0)
            return {16'($urandom), 16'($urandom), 16'($urandom)};
        p.intensity  = near(lo_now.intensity, hi_now.intensity);
        p.hue        = near(lo_now.hue, hi_now.hue);
        p.saturation = near(lo_now.saturation, hi_now.saturation);
        return p;
    endfunction

    // Keep valid high across back-to-back requests; drop it only for a gap
    task automatic send_pixel(bound_t pix);
        int gap;

        gap = idle_mode[0] ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        intensity   <= pix.intensity;
        hue         <= pix.hue;
        saturation  <= pix.saturation;
        do @(posedge clk); while (!pixel_ready);
        sb.take_pixel(pix);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(bound_t lo, bound_t hi,
                             logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        lo_now = lo;
        hi_now = hi;
        write_reg(REG_LOW_INTENSITY, lo.intensity);
        write_reg(REG_LOW_HUE, lo.hue);
        write_reg(REG_LOW_SATURATION, lo.saturation);
        write_reg(REG_HIGH_INTENSITY, hi.intensity);
        write_reg(REG_HIGH_HUE, hi.hue);
        write_reg(REG_HIGH_SATURATION, hi.saturation);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every outstanding result, then let the pipeline settle
    task automatic drain();
        pixel_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase();
        bound_t a;
        bound_t b;
        bound_t t;
        int     w;
        int     n;

        a = {16'($urandom), 16'($urandom), 16'($urandom)};
        b = {16'($urandom), 16'($urandom), 16'($urandom)};
        // tie the leading keys now and then so the later keys decide
        if ($urandom_range(0, 2) == 0)
            b.intensity = a.intensity;
        if ($urandom_range(0, 3) == 0)
            b.hue = a.hue;
        if ($urandom_range(0, 4) != 0 && a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        w = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(2, 9);
        idle_mode = 2'($urandom_range(0, 3));
        configure(a, b, 16'(w), 16'($urandom_range(2, 8)));
        n = $urandom_range(20, 90);
        repeat (n) send_pixel(pick_pixel());
        random_sent += n;
        drain();
    endtask

    initial
    begin
        bound_t board [12];

        // checkerboard of inside and outside pixels, every bound hit exactly
        board = '{48'h0100_0200_0300, 48'h0000_0000_0000,
                  48'hF000_0040_0050, 48'hFFFF_FFFF_FFFF,
                  48'h0100_0200_02FF, 48'h0100_FFFF_0000,
                  48'hF000_0040_0051, 48'hF000_0000_FFFF,
                  48'h8000_1234_ABCD, 48'h00FF_FFFF_FFFF,
                  48'hEFFF_FFFF_FFFF, 48'hF001_0000_0000};
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        hue         = '0;
        saturation  = '0;
        intensity   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_LOW_INTENSITY;
        cfg_data    = '0;
        idle_mode   = 2'b11;
        random_sent = 0;
        lo_now      = '0;
        hi_now      = '1;
        sb          = new;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(48'h0100_0200_0300, 48'hF000_0040_0050, 16'd4, 16'd3);
        foreach (board[k])
            send_pixel(board[k]);
        drain();

        // full range, sizes below the minimum
        configure('0, '1, 16'd0, 16'd1);
        repeat (8) send_pixel(pick_pixel());
        drain();

        // empty range: low above high
        configure('1, '0, 16'd1, 16'd0);
        repeat (8) send_pixel(pick_pixel());
        drain();

        // one-point range on an oversized row, then shrink the width mid-row
        idle_mode = 2'b00;
        configure({3{16'h8000}}, {3{16'h8000}}, 16'hFFFF, 16'd2);
        repeat (40) send_pixel(pick_pixel());
        drain();
        write_reg(REG_IMAGE_WIDTH, 16'd5);
        cfg_valid <= 1'b0;
        repeat (30) send_pixel(pick_pixel());
        drain();

        // tallest frame, then shrink the height below the current row
        idle_mode = 2'b11;
        configure(48'h4000_0000_0000, 48'hC000_FFFF_FFFF, 16'd2, 16'd1024);
        repeat (30) send_pixel(pick_pixel());
        drain();
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        cfg_valid <= 1'b0;
        repeat (20) send_pixel(pick_pixel());
        drain();

        while (random_sent < RANDOM_ITEMS)
            random_phase();

        if (sb.mismatches == 0)
            $display("** level_set_edge_map: PASSED **");
        else
            $display("** level_set_edge_map: FAILED **");
        $finish;
    end

    // Result side: with idle_mode bit 1 set, stall a random number of cycles before each request
    initial
    begin
        int           stall;
        edge_result_t got;

        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_mode[1] ? $urandom_range(0, 17) : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            got = {pixel_inside, left_edge, up_edge, point_count, count_done};
            sb.match_result(got);
        end
    end

    initial
    begin
        #3000000;
        $display("** level_set_edge_map: FAILED **");
        $finish;
    end

endmodule
